>>> src/pis_pkg.sv
// ----------------------------------------------------------------------------
// pis_pkg
// Shared types and constants for the prefix interpolation search core.
// ----------------------------------------------------------------------------
package pis_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 4096;
  localparam int unsigned KEY_W           = 64;
  localparam int unsigned SCALAR_W        = 31;
  localparam int unsigned COUNT_W         = 13;
  localparam int unsigned INDEX_W         = 12;
  localparam int unsigned PREFIX_W        = 32;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SEARCH = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT_RD0,
    ST_INIT_RDH,
    ST_INIT_CAP,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_RD,
    ST_CMP,
    ST_PRD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                cmd;
    logic [INDEX_W-1:0]  entry_index;
    logic [KEY_W-1:0]    key_word_0;
    logic [KEY_W-1:0]    key_word_1;
    logic [KEY_W-1:0]    key_word_2;
    logic [KEY_W-1:0]    key_word_3;
    logic [SCALAR_W-1:0] entry_scalar;
  } in_item_t;

  typedef struct packed {
    logic                found;
    logic [SCALAR_W-1:0] match_scalar;
  } out_item_t;

endpackage

>>> src/pis_if.sv
// ----------------------------------------------------------------------------
// pis_in_if / pis_out_if
// Valid/ready channels for input and result transactions.
// ----------------------------------------------------------------------------
interface pis_in_if;
  import pis_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pis_out_if;
  import pis_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/pis_ram.sv
// ----------------------------------------------------------------------------
// pis_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module pis_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write one entry when we is set; read the addressed entry (old data on a write)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> src/prefix_interpolation_search_core.sv
// ----------------------------------------------------------------------------
// prefix_interpolation_search_core
// Sorted 256-bit key table with interpolation search over key prefixes.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                   | role
//  in      | in  | command, entry_index, key_word_0..3, scal | load or search
//  out     | out | found, match_scalar                       | search result
//  cfg     | in  | entry_count (13 bit)                      | table size
//
// A load is written on acceptance. A search runs ST_INIT_RD0, ST_INIT_RDH,
// ST_INIT_CAP, then per probe ST_CHECK, ST_MUL, ST_DIV (restoring divider,
// one quotient bit per cycle over PW, the product width: bound width plus
// 32), ST_PRD, ST_RD and ST_CMP. A probe with equal bound prefixes skips
// ST_MUL, ST_DIV and ST_PRD. Reset is synchronous; the table is not cleared.
// in_ready is low while a search runs or its result waits on out_ready.
module prefix_interpolation_search_core #(
  parameter int unsigned TABLE_DEPTH = pis_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  pis_in_if.sink                       in_ch,
  pis_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [pis_pkg::COUNT_W-1:0]  cfg_wdata
);
  import pis_pkg::*;

  localparam int unsigned AW  = $clog2(TABLE_DEPTH);
  localparam int unsigned BW  = AW + 1;          // bound width
  localparam int unsigned PW  = BW + PREFIX_W;   // product width
  localparam int unsigned DCW = $clog2(PW + 1);

  state_t state_r, state_nxt;

  logic [COUNT_W-1:0]  count_cfg_r;
  logic [BW-1:0]       lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  logic [PREFIX_W-1:0] lp_r, lp_nxt, rp_r, rp_nxt;
  logic [KEY_W-1:0]    k0_r, k1_r, k2_r, k3_r;
  logic [PW-1:0]       num_r, num_nxt;       // dividend / quotient shift
  logic [PREFIX_W:0]   rem_r, rem_nxt;
  logic [PREFIX_W-1:0] den_r, den_nxt;
  logic [DCW-1:0]      dcnt_r, dcnt_nxt;
  logic                ov_valid_r, ov_valid_nxt;
  out_item_t           ov_r, ov_nxt;
  logic                cap_k;

  // ram signals
  logic                ram_we;
  logic [AW-1:0]       ram_addr;
  logic [KEY_W-1:0]    r0, r1, r2, r3;
  logic [SCALAR_W-1:0] rs;
  logic [KEY_W-1:0]    w0, w1, w2, w3;
  logic [SCALAR_W-1:0] ws;

  logic                in_acc;
  logic [BW-1:0]       cnt_clip;
  logic [PREFIX_W-1:0] my;
  logic [PREFIX_W:0]   rem_sh;
  logic [PW-1:0]       sum_mid;
  logic                lt, gt;

  assign in_ch.ready  = (state_r == ST_IDLE) && !ov_valid_r;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = ov_valid_r;
  assign out_ch.data  = ov_r;
  assign my           = k0_r[KEY_W-1 -: PREFIX_W];

  assign w0 = in_ch.data.key_word_0;
  assign w1 = in_ch.data.key_word_1;
  assign w2 = in_ch.data.key_word_2;
  assign w3 = in_ch.data.key_word_3;
  assign ws = in_ch.data.entry_scalar;

  // clip count to depth
  always_comb begin
    if ({{(32-COUNT_W){1'b0}}, count_cfg_r} > 32'(TABLE_DEPTH)) begin
      cnt_clip = BW'(TABLE_DEPTH);
    end else begin
      cnt_clip = BW'(count_cfg_r);
    end
  end

  // 256-bit compare of stored entry against key
  always_comb begin
    lt = 1'b0;
    gt = 1'b0;
    if (r0 != k0_r) begin
      lt = r0 < k0_r; gt = r0 > k0_r;
    end else if (r1 != k1_r) begin
      lt = r1 < k1_r; gt = r1 > k1_r;
    end else if (r2 != k2_r) begin
      lt = r2 < k2_r; gt = r2 > k2_r;
    end else if (r3 != k3_r) begin
      lt = r3 < k3_r; gt = r3 > k3_r;
    end
  end

  assign rem_sh  = {rem_r[PREFIX_W-1:0], num_r[PW-1]};
  assign sum_mid = PW'(lo_r) + num_r;

  // table memories
  pis_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_k0 (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(w0), .rdata(r0));
  pis_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_k1 (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(w1), .rdata(r1));
  pis_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_k2 (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(w2), .rdata(r2));
  pis_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_k3 (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(w3), .rdata(r3));
  pis_ram #(.WIDTH(SCALAR_W), .DEPTH(TABLE_DEPTH)) u_sc (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ws), .rdata(rs));

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ov_valid_r  <= 1'b0;
      count_cfg_r <= '0;
      lo_r        <= '0;
      hi_r        <= '0;
      lp_r        <= '0;
      rp_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      ov_valid_r <= ov_valid_nxt;
      lo_r       <= lo_nxt;
      hi_r       <= hi_nxt;
      lp_r       <= lp_nxt;
      rp_r       <= rp_nxt;
      if (cfg_we) begin
        count_cfg_r <= cfg_wdata;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mid_r  <= mid_nxt;
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    dcnt_r <= dcnt_nxt;
    ov_r   <= ov_nxt;
    if (cap_k) begin
      k0_r <= in_ch.data.key_word_0;
      k1_r <= in_ch.data.key_word_1;
      k2_r <= in_ch.data.key_word_2;
      k3_r <= in_ch.data.key_word_3;
    end
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    ov_valid_nxt = ov_valid_r;
    ov_nxt       = ov_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    lp_nxt       = lp_r;
    rp_nxt       = rp_r;
    mid_nxt      = mid_r;
    num_nxt      = num_r;
    rem_nxt      = rem_r;
    den_nxt      = den_r;
    dcnt_nxt     = dcnt_r;
    cap_k        = 1'b0;
    ram_we       = 1'b0;
    ram_addr     = mid_r[AW-1:0];
    if (ov_valid_r && out_ch.ready) begin
      ov_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.data.cmd == CMD_LOAD) begin
            // write one entry when the index fits
            ram_addr = AW'(in_ch.data.entry_index);
            ram_we   = ({{(32-INDEX_W){1'b0}}, in_ch.data.entry_index}
                        < 32'(TABLE_DEPTH));
          end else begin
            cap_k = 1'b1;
            if (cnt_clip == '0) begin
              ov_nxt       = '0;
              ov_valid_nxt = 1'b1;
            end else begin
              lo_nxt    = '0;
              hi_nxt    = cnt_clip - BW'(1);
              state_nxt = ST_INIT_RD0;
            end
          end
        end
      end
      ST_INIT_RD0: begin
        ram_addr  = '0;
        state_nxt = ST_INIT_RDH;
      end
      ST_INIT_RDH: begin
        lp_nxt    = r0[KEY_W-1 -: PREFIX_W];
        ram_addr  = hi_r[AW-1:0];
        state_nxt = ST_INIT_CAP;
      end
      ST_INIT_CAP: begin
        rp_nxt    = r0[KEY_W-1 -: PREFIX_W];
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        // range check, then a direct read on equal bound prefixes or the division
        if (my < lp_r || my > rp_r) begin
          ov_nxt       = '0;
          ov_valid_nxt = 1'b1;
          state_nxt    = ST_IDLE;
        end else if (lp_r == rp_r) begin
          mid_nxt   = lo_r;
          state_nxt = ST_RD;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        num_nxt   = PW'(hi_r - lo_r) * PW'(my - lp_r);
        rem_nxt   = '0;
        den_nxt   = rp_r - lp_r;
        dcnt_nxt  = DCW'(PW);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // one restoring quotient bit per cycle
        if (rem_sh >= {1'b0, den_r}) begin
          rem_nxt = rem_sh - {1'b0, den_r};
          num_nxt = {num_r[PW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          num_nxt = {num_r[PW-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r - DCW'(1);
        if (dcnt_r == DCW'(1)) begin
          state_nxt = ST_PRD;
        end
      end
      ST_PRD: begin
        mid_nxt   = sum_mid[BW-1:0];
        state_nxt = ST_RD;
      end
      ST_RD: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (!lt && !gt) begin
          ov_nxt       = '{found: 1'b1, match_scalar: rs};
          ov_valid_nxt = 1'b1;
          state_nxt    = ST_IDLE;
        end else if (lt) begin
          if (mid_r >= hi_r) begin
            ov_nxt       = '0;
            ov_valid_nxt = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            lo_nxt    = mid_r + BW'(1);
            lp_nxt    = r0[KEY_W-1 -: PREFIX_W];
            state_nxt = ST_CHECK;
          end
        end else begin
          if (mid_r <= lo_r) begin
            ov_nxt       = '0;
            ov_valid_nxt = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            hi_nxt    = mid_r - BW'(1);
            rp_nxt    = r0[KEY_W-1 -: PREFIX_W];
            state_nxt = ST_CHECK;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end
endmodule

>>> tb/tb_prefix_interpolation_search_core.sv
// ----------------------------------------------------------------------------
// tb_prefix_interpolation_search_core
// Self-checking bench: loads sorted 256-bit key tables, sweeps entry_count,
// runs directed and random searches under random idling and backpressure,
// and compares every result against an in-bench interpolation search.
// ----------------------------------------------------------------------------
module tb_prefix_interpolation_search_core;
  import pis_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH = TABLE_DEPTH_DEF;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;

  pis_in_if  in_ch ();
  pis_out_if out_ch ();

  prefix_interpolation_search_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Mirror of the block: table contents and the count register
  bit [255:0]        key_mem [DEPTH];
  bit [SCALAR_W-1:0] scalar_mem [DEPTH];
  int unsigned       count_reg;

  out_item_t   pending_results[$];
  bit [255:0]  sorted_keys[$];
  int unsigned errors;
  int unsigned n_loads, n_searches, n_hits;
  int unsigned snd_idle_pct, rcv_stall_pct;
  int unsigned hold_len, hold_tag, seen_tag, hold_left;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Global watchdog
  initial begin
    #20ms;
    $display("prefix_interpolation_search_core verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint unsigned exp_v,
                                 input longint unsigned got_v);
    errors++;
    $display("[%0t] MISMATCH %s: expected %0h got %0h", $realtime, what, exp_v, got_v);
  endtask

  // Interpolation search over the mirrored table
  function automatic out_item_t search_table(bit [255:0] key);
    out_item_t          res;
    longint unsigned    cnt, lo, hi, mid;
    bit [PREFIX_W-1:0]  lp, rp, my;
    res = '0;
    cnt = (count_reg > DEPTH) ? DEPTH : count_reg;
    if (cnt == 0) return res;
    lo = 0;
    hi = cnt - 1;
    lp = key_mem[0][255:224];
    rp = key_mem[hi][255:224];
    my = key[255:224];
    while (1) begin
      if (my < lp || my > rp) return res;
      if (lp == rp) mid = lo;
      else mid = lo + ((hi - lo) * longint'(my - lp)) / longint'(rp - lp);
      if (key_mem[mid] == key) begin
        res.found = 1'b1;
        res.match_scalar = scalar_mem[mid];
        return res;
      end
      if (key_mem[mid] < key) begin
        if (mid >= hi) return res;
        lo = mid + 1;
        lp = key_mem[mid][255:224];
      end else begin
        if (mid <= lo) return res;
        hi = mid - 1;
        rp = key_mem[mid][255:224];
      end
    end
    return res;
  endfunction

  // Update the mirror for one accepted transaction
  task automatic apply_item(input in_item_t it);
    bit [255:0] k;
    out_item_t  r;
    k = {it.key_word_0, it.key_word_1, it.key_word_2, it.key_word_3};
    if (cmd_t'(it.cmd) == CMD_LOAD) begin
      key_mem[it.entry_index] = k;
      scalar_mem[it.entry_index] = it.entry_scalar;
      n_loads++;
    end else begin
      r = search_table(k);
      pending_results.push_back(r);
      n_searches++;
      if (r.found) n_hits++;
    end
  endtask

  // Offer one transaction; hold valid until accepted
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(0, 99) < snd_idle_pct) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    apply_item(it);
  endtask

  task automatic send_load(input int unsigned idx, input bit [255:0] k,
                           input bit [SCALAR_W-1:0] s);
    in_item_t it;
    it.cmd = CMD_LOAD;
    it.entry_index = INDEX_W'(idx);
    {it.key_word_0, it.key_word_1, it.key_word_2, it.key_word_3} = k;
    it.entry_scalar = s;
    send_item(it);
  endtask

  task automatic send_search(input bit [255:0] k);
    in_item_t it;
    it.cmd = CMD_SEARCH;
    it.entry_index = INDEX_W'($urandom_range(0, DEPTH - 1));
    {it.key_word_0, it.key_word_1, it.key_word_2, it.key_word_3} = k;
    it.entry_scalar = SCALAR_W'($urandom);
    send_item(it);
  endtask

  // Drop valid, drain all results, let a trailing load settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_entry_count(input int unsigned n);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= COUNT_W'(n);
    @(posedge clk);
    count_reg = n;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idling(input int unsigned ph);
    case (ph % 4)
      0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
      1: begin snd_idle_pct = 58; rcv_stall_pct = 0;  end
      2: begin snd_idle_pct = 0;  rcv_stall_pct = 58; end
      default: begin snd_idle_pct = 30; rcv_stall_pct = 30; end
    endcase
  endtask

  function automatic bit [255:0] rand_key();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // Build n sorted keys and load them at 0..n-1.
  // Spread: 0 wide prefixes, 1 a few prefixes, 2 one prefix, 3 wide with extreme ends
  task automatic load_sorted(input int unsigned n, input int unsigned spread);
    bit [255:0]  k;
    bit [31:0]   base;
    int unsigned i;
    sorted_keys.delete();
    base = $urandom;
    for (i = 0; i < n; i++) begin
      k = rand_key();
      if (spread == 1) k[255:224] = base + $urandom_range(0, 3);
      else if (spread == 2) k[255:224] = base;
      sorted_keys.push_back(k);
    end
    if (spread == 3) begin
      sorted_keys[0] = '0;
      if (n > 1) sorted_keys[n - 1] = '1;
    end
    sorted_keys.sort();
    for (i = 0; i < n; i++) send_load(i, sorted_keys[i], SCALAR_W'($urandom));
  endtask

  // Search key: half table hits, the rest near misses and random keys
  function automatic bit [255:0] pick_key(input int unsigned n);
    bit [255:0]  k;
    int unsigned r;
    r = $urandom_range(0, 9);
    k = key_mem[$urandom_range(0, n - 1)];
    if (r < 5) return k;
    if (r < 7) return k + ($urandom_range(0, 1) ? 256'd1 : -256'd1);
    if (r < 8) begin
      k[255:224] = k[255:224] + $urandom_range(1, 3);
      return k;
    end
    return rand_key();
  endfunction

  // Result checker
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no search outstanding", 64'(0), 64'(out_ch.data));
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.data.found !== exp_r.found)
          report_mismatch("found", 64'(exp_r.found), 64'(out_ch.data.found));
        if (out_ch.data.match_scalar !== exp_r.match_scalar)
          report_mismatch("match_scalar", 64'(exp_r.match_scalar),
                          64'(out_ch.data.match_scalar));
      end
    end
  end

  // Receiver: long hold-off counted in cycles when requested, else random stalls
  always @(posedge clk) begin
    if (hold_tag != seen_tag) begin
      seen_tag  = hold_tag;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  // Empty table: reset count and an explicit zero write
  task automatic test_empty_table();
    send_search(rand_key());
    send_search('0);
    set_entry_count(0);
    send_search('1);
  endtask

  // Directed: hits at both ends, prefix below and above the bounds,
  // a miss between entries, equal bound prefixes, single entry
  task automatic test_directed();
    bit [255:0] k;
    int unsigned i;
    send_load(0, {32'h0000_0100, 224'h0}, '0);
    send_load(1, {32'h1000_0000, 224'h5}, 31'h1234);
    send_load(2, {32'h2000_0000, 224'h7}, 31'h2345);
    send_load(3, {32'h3000_0000, 224'h9}, 31'h3456);
    send_load(4, {32'h8000_0000, 224'h1}, 31'h4567);
    send_load(5, {32'hFFFF_FFFE, {224{1'b1}}}, 31'h7FFF_FFFF);
    set_entry_count(6);
    send_search({32'h0000_0100, 224'h0});
    send_search({32'hFFFF_FFFE, {224{1'b1}}});
    send_search({32'h3000_0000, 224'h9});
    send_search('0);
    send_search('1);
    send_search({32'h2000_0000, 224'h8});
    set_entry_count(1);
    send_search({32'h0000_0100, 224'h0});
    for (i = 0; i < 4; i++) send_load(i, {32'h0000_0007, 224'(i * 3 + 1)}, 31'(i + 10));
    set_entry_count(4);
    send_search({32'h0000_0007, 224'd10});
    send_search({32'h0000_0007, 224'd5});
    k = {32'h0000_0007, 224'd4};
    send_search(k);
  endtask

  // Count at and beyond the depth: only the first and last entries are
  // loaded, so searches stick to keys that probe just those two
  task automatic test_count_clip();
    bit [255:0]  k_lo, k_hi;
    int unsigned rep, i;
    k_lo = rand_key();
    k_lo[255:224] = 32'h0000_1000;
    k_hi = rand_key();
    k_hi[255:224] = 32'hF000_0000;
    set_idling(0);
    send_load(0, k_lo, SCALAR_W'($urandom));
    send_load(DEPTH - 1, k_hi, SCALAR_W'($urandom));
    for (rep = 0; rep < 3; rep++) begin
      case (rep)
        0: set_entry_count(DEPTH);
        1: set_entry_count((1 << COUNT_W) - 1);
        default: set_entry_count(DEPTH + 1);
      endcase
      set_idling(rep * 3);
      for (i = 0; i < 2; i++) begin
        send_search(k_lo);
        send_search(k_hi);
        send_search('0);
        send_search('1);
      end
    end
  endtask

  // Receiver holds off while searches keep coming, stalling the input
  task automatic test_backpressure();
    int unsigned i;
    set_idling(0);
    load_sorted(32, 0);
    set_entry_count(32);
    hold_len = 400;
    hold_tag++;
    for (i = 0; i < 12; i++) send_search(pick_key(32));
  endtask

  // Random tables of varied size and prefix spread, then random searches
  task automatic test_random_tables();
    int unsigned ph, n, spread, cnt, i, r;
    for (ph = 0; ph < 16; ph++) begin
      set_idling(ph);
      r = $urandom_range(0, 9);
      spread = $urandom_range(0, 3);
      if (r < 6) n = $urandom_range(1, 16);
      else if (r < 9) n = $urandom_range(17, 64);
      else n = $urandom_range(65, 200);
      if (spread inside {1, 2} && n > 64) n = 64;
      load_sorted(n, spread);
      for (i = 0; i < 3; i++) begin
        send_load($urandom_range(n, DEPTH - 1), rand_key(), SCALAR_W'($urandom));
      end
      cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n) : n;
      set_entry_count(cnt);
      for (i = 0; i < 20; i++) send_search(pick_key(cnt));
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    count_reg    = 0;
    errors       = 0;
    n_loads      = 0;
    n_searches   = 0;
    n_hits       = 0;
    hold_len     = 0;
    hold_tag     = 0;
    seen_tag     = 0;
    hold_left    = 0;
    set_idling(0);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_directed();
    test_count_clip();
    test_backpressure();
    test_random_tables();

    wait_idle();
    $display("Covered %0d loads and %0d searches (%0d hits), entry_count from 0 to %0d,",
             n_loads, n_searches, n_hits, (1 << COUNT_W) - 1);
    $display("under sender idling, receiver stalls and one long receiver hold-off.");
    if (errors == 0) begin
      $display("prefix_interpolation_search_core verification clean");
    end else begin
      $display("prefix_interpolation_search_core verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/pis_pkg.sv
src/pis_if.sv
src/pis_ram.sv
src/prefix_interpolation_search_core.sv
tb/tb_prefix_interpolation_search_core.sv
